### sv/slr_pkg.sv
`default_nettype none

package slr_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned FRAC_BITS   = 16;

  // The step and the position carry four integer bits above the fraction plus one
  // more, so a position of one plus the largest step still fits.
  localparam int unsigned STEP_W = FRAC_BITS + 5;
  localparam int unsigned DIFF_W = SAMPLE_BITS + 1;
  localparam int unsigned OPND_W = STEP_W + 1;
  localparam int unsigned PROD_W = DIFF_W + OPND_W;
  localparam int unsigned ACC_W  = PROD_W + 1;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = 4;

  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_MIN = STEP_ONE >> 4;
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_ONE << 4;
  localparam logic [ACC_W-1:0]  ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(MAX_RESULTS - 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the new sample and its difference to the previous one
    logic first;       // store the very first sample, emit nothing
    logic skip;        // position already past one: emit nothing, move on
    logic mul_pos;     // acc <= diff * frac(position)
    logic mul_step;    // dstep <= diff * step
    logic emit_pass;   // load the output register with the sample as is
    logic emit_interp; // load the output register with the next interpolated value
  } slr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pass;        // step equals one
    logic have_prev;
    logic pos_ge_one;
    logic out_free;    // output register can take a new beat this cycle
    logic last;        // the value being emitted ends the run
  } slr_sts_t;

endpackage

`default_nettype wire

### sv/slr_in_if.sv
`default_nettype none

interface slr_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [slr_pkg::SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

### sv/slr_out_if.sv
`default_nettype none

interface slr_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [slr_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                   last_of_run;

  modport source (output valid, output sample_out, output last_of_run, input ready);
  modport sink   (input valid, input sample_out, input last_of_run, output ready);
endinterface

`default_nettype wire

### sv/slr_cfg_if.sv
`default_nettype none

interface slr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [slr_pkg::STEP_W-1:0]      step_q16;

  modport source (output valid, output step_q16, input ready);
  modport sink   (input valid, input step_q16, output ready);
endinterface

`default_nettype wire

### sv/streaming_linear_resampler.sv
// Linear interpolation sample-rate converter for signed audio samples.
// in_if carries one sample per beat; out_if carries interpolated samples, with
// last_of_run set on the final beat caused by an input sample; cfg_if writes
// the Q16 step (source over destination rate), clamped to 1/16 .. 16, and is
// always ready. Write it only while the block is idle.
// With a step other than one, the very first sample after reset, and any
// sample arriving while the position is at or past one, produces no beat.
// With a step of exactly one each sample passes straight through: it is
// captured, then loaded into the output register once that is free, and
// the next sample is taken only after that.
// Otherwise the block uses the multiplier twice (diff * position, then
// diff * step) and then emits one beat per cycle from an accumulator while
// the output register is free; an input yields at most 16 beats.
// The output register holds a finished beat while the receiver stalls; the
// run then pauses, and no input is taken until the run is over.
// Reset restores a step of one, clears the position and forgets the
// previous sample.
`default_nettype none

module streaming_linear_resampler (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  slr_in_if.sink     in_if,
  slr_cfg_if.sink    cfg_if,
  slr_out_if.source  out_if
);

  slr_pkg::slr_cmd_t cmd;
  slr_pkg::slr_sts_t sts;

  assign cfg_if.ready = 1'b1;

  slr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  slr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_step_i   (cfg_if.step_q16),
    .in_sample_i  (in_if.sample_in),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_if.ready),
    .out_valid_o  (out_if.valid),
    .out_sample_o (out_if.sample_out),
    .out_last_o   (out_if.last_of_run)
  );

endmodule

`default_nettype wire

### sv/slr_datapath.sv
`default_nettype none

module slr_datapath (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_valid_i,
  input  wire logic [slr_pkg::STEP_W-1:0]             cfg_step_i,
  input  wire logic signed [slr_pkg::SAMPLE_BITS-1:0] in_sample_i,
  input  wire slr_pkg::slr_cmd_t                      cmd_i,
  output slr_pkg::slr_sts_t                           sts_o,
  input  wire logic                                   out_ready_i,
  output logic                                        out_valid_o,
  output logic signed [slr_pkg::SAMPLE_BITS-1:0]      out_sample_o,
  output logic                                        out_last_o
);

  localparam int unsigned SB = slr_pkg::SAMPLE_BITS;
  localparam int unsigned FB = slr_pkg::FRAC_BITS;
  localparam int unsigned SW = slr_pkg::STEP_W;

  logic [SW-1:0]                    step_q, step_d;
  logic signed [SB-1:0]             prev_q, cur_q;
  logic                             have_q;
  logic [SW-1:0]                    pos_q, pos_d;
  logic signed [slr_pkg::DIFF_W-1:0] diff_q, diff_d;
  logic signed [slr_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [slr_pkg::PROD_W-1:0] dstep_q;
  logic [slr_pkg::CNT_W-1:0]        cnt_q;
  logic                             out_valid_q;
  logic signed [SB-1:0]             out_sample_q;
  logic                             out_last_q;

  logic [slr_pkg::OPND_W-1:0]        opnd;
  logic signed [slr_pkg::PROD_W-1:0] prod;
  logic signed [slr_pkg::ACC_W-1:0]  rounded;
  logic signed [slr_pkg::ACC_W-1:0]  shifted;
  logic signed [SB-1:0]              interp;
  logic [SW:0]                       pos_sum;
  logic                              sum_ge_one;
  logic                              last;

  // Clamp the written step into the supported range once, at the write.
  always_comb begin
    step_d = cfg_step_i;
    if (cfg_step_i < slr_pkg::STEP_MIN) begin
      step_d = slr_pkg::STEP_MIN;
    end else if (cfg_step_i > slr_pkg::STEP_MAX) begin
      step_d = slr_pkg::STEP_MAX;
    end
  end

  assign diff_d = {in_sample_i[SB-1], in_sample_i} - {prev_q[SB-1], prev_q};

  // Inside a run the position stays below one, so diff * position advances by
  // exactly diff * step per output and one multiplier set-up per run suffices.
  assign opnd = cmd_i.mul_step ? {1'b0, step_q}
                               : slr_pkg::OPND_W'(pos_q[FB-1:0]);
  assign prod = diff_q * $signed(opnd);

  assign rounded = acc_q + $signed(slr_pkg::ACC_HALF);
  assign shifted = rounded >>> FB;
  assign interp  = prev_q + shifted[SB-1:0];

  assign pos_sum    = {1'b0, pos_q} + {1'b0, step_q};
  assign sum_ge_one = pos_sum >= {1'b0, slr_pkg::STEP_ONE};
  assign last       = sum_ge_one || (cnt_q == slr_pkg::CNT_LAST);

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.skip) begin
      pos_d = pos_q - slr_pkg::STEP_ONE;
    end else if (cmd_i.emit_interp) begin
      if (!last) begin
        pos_d = pos_sum[SW-1:0];
      end else if (sum_ge_one) begin
        pos_d = pos_sum[SW-1:0] - slr_pkg::STEP_ONE;
      end else begin
        pos_d = '0;
      end
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.mul_pos) begin
      acc_d = {prod[slr_pkg::PROD_W-1], prod};
    end else if (cmd_i.emit_interp) begin
      acc_d = acc_q + {dstep_q[slr_pkg::PROD_W-1], dstep_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= slr_pkg::STEP_ONE;
      prev_q      <= '0;
      have_q      <= 1'b0;
      pos_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        step_q <= step_d;
      end
      pos_q <= pos_d;
      if (cmd_i.first || cmd_i.skip) begin
        prev_q <= in_sample_i;
        have_q <= 1'b1;
      end else if (cmd_i.emit_pass || (cmd_i.emit_interp && last)) begin
        prev_q <= cur_q;
        have_q <= 1'b1;
      end
      if (cmd_i.capture) begin
        cnt_q <= '0;
      end else if (cmd_i.emit_interp) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.emit_pass || cmd_i.emit_interp) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_q  <= in_sample_i;
      diff_q <= diff_d;
    end
    acc_q <= acc_d;
    if (cmd_i.mul_step) begin
      dstep_q <= prod;
    end
    if (cmd_i.emit_pass) begin
      out_sample_q <= cur_q;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit_interp) begin
      out_sample_q <= interp;
      out_last_q   <= last;
    end
  end

  assign sts_o.pass       = step_q == slr_pkg::STEP_ONE;
  assign sts_o.have_prev  = have_q;
  assign sts_o.pos_ge_one = pos_q >= slr_pkg::STEP_ONE;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.last       = last;

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

### sv/slr_ctrl.sv
`default_nettype none

module slr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire slr_pkg::slr_sts_t sts_i,
  output slr_pkg::slr_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_POS,
    ST_MUL_STEP,
    ST_EMIT,
    ST_PASS
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;
  logic   take;

  assign take = ready_q && in_valid_i;

  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (sts_i.pass) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_PASS;
            ready_d       = 1'b0;
          end else if (!sts_i.have_prev) begin
            cmd_o.first = 1'b1;
          end else if (sts_i.pos_ge_one) begin
            cmd_o.skip = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = ST_MUL_POS;
            ready_d       = 1'b0;
          end
        end
      end
      ST_MUL_POS: begin
        cmd_o.mul_pos = 1'b1;
        state_d       = ST_MUL_STEP;
      end
      ST_MUL_STEP: begin
        cmd_o.mul_step = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_interp = 1'b1;
          if (sts_i.last) begin
            state_d = ST_IDLE;
            ready_d = 1'b1;
          end
        end
      end
      ST_PASS: begin
        if (sts_i.out_free) begin
          cmd_o.emit_pass = 1'b1;
          state_d         = ST_IDLE;
          ready_d         = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
        ready_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  assign in_ready_o = ready_q;

endmodule

`default_nettype wire
